/* rtl/dri_pkg.sv */
// dri_pkg: shared types, constants and the arctangent table for the pose integrator
// used by dri_ctrl, dri_datapath and dead_reckoning_pose_integrator
// no dependencies
package dri_pkg;

  localparam int DRI_CORDIC_STEPS = 24;
  localparam int DRI_ATAN_DEPTH   = 32;
  localparam int DRI_CFG_IDX_W    = 8;
  localparam int DRI_TDATA_IN_W   = 32;
  localparam int DRI_TDATA_OUT_W  = 168;

  // register indexes on the configuration channel
  localparam logic [DRI_CFG_IDX_W-1:0] DRI_REG_SPEED_GAIN   = 8'd0;
  localparam logic [DRI_CFG_IDX_W-1:0] DRI_REG_SPEED_OFFSET = 8'd1;
  localparam logic [DRI_CFG_IDX_W-1:0] DRI_REG_TURN_GAIN    = 8'd2;
  localparam logic [DRI_CFG_IDX_W-1:0] DRI_REG_TURN_OFFSET  = 8'd3;

  localparam logic signed [31:0] DRI_SPEED_GAIN_RST   = 32'sd108203;
  localparam logic signed [31:0] DRI_SPEED_OFFSET_RST = 32'sd396397;
  localparam logic signed [31:0] DRI_TURN_GAIN_RST    = 32'sd3950442;
  localparam logic signed [31:0] DRI_TURN_OFFSET_RST  = 32'sd614600;

  // cordic gain limit in Q2.30, carried in the 34-bit rotation width
  localparam logic signed [33:0] DRI_CORDIC_K = 34'sh026DD3B6A;

  localparam logic signed [47:0] DRI_POS_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] DRI_POS_MIN = 48'sh8000_0000_0000;

  // quadrant codes from the top two heading bits
  localparam logic [1:0] DRI_QUAD_0 = 2'd0;
  localparam logic [1:0] DRI_QUAD_1 = 2'd1;
  localparam logic [1:0] DRI_QUAD_2 = 2'd2;

  typedef struct packed {
    logic load;
    logic scale;
    logic update;
    logic rot;
    logic mulx;
    logic accx;
    logic muly;
    logic accy;
    logic emit;
  } dri_cmd_t;

  typedef struct packed {
    logic rot_last;
  } dri_sts_t;

  // arctangent of 2^-i as binary angle, full turn 2^32
  function automatic logic [31:0] dri_atan(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

/* rtl/dri_ctrl.sv */
// dri_ctrl: sequencer for one pose update and the output handshake
// depends on dri_pkg (command and status structs)
module dri_ctrl
  import dri_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output dri_cmd_t cmd,
  input  dri_sts_t sts
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SCALE  = 9'b000000010,
    ST_UPDATE = 9'b000000100,
    ST_ROT    = 9'b000001000,
    ST_MULX   = 9'b000010000,
    ST_ACCX   = 9'b000100000,
    ST_MULY   = 9'b001000000,
    ST_ACCY   = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_ROT;
      end
      ST_ROT: begin
        cmd.rot = 1'b1;
        if (sts.rot_last) begin
          state_next = ST_MULX;
        end
      end
      ST_MULX: begin
        cmd.mulx   = 1'b1;
        state_next = ST_ACCX;
      end
      ST_ACCX: begin
        cmd.accx   = 1'b1;
        state_next = ST_MULY;
      end
      ST_MULY: begin
        cmd.muly   = 1'b1;
        state_next = ST_ACCY;
      end
      ST_ACCY: begin
        cmd.accy   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_load_to_scale: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_SCALE)
    else $error("accepted transaction did not start scaling");

  a_rot_exit: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROT && sts.rot_last |=> state == ST_MULX)
    else $error("rotation did not hand over to the multiplier");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_tvalid)
    else $error("result loaded but not presented");

  a_cmd_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

endmodule

/* rtl/dri_datapath.sv */
// dri_datapath: configuration registers, scaling, heading, cordic and position accumulators
// depends on dri_pkg (constants, atan table, command and status structs)
module dri_datapath
  import dri_pkg::*;
#(
  parameter int CORDIC_STEPS = DRI_CORDIC_STEPS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [DRI_CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic [DRI_TDATA_IN_W-1:0]  in_data,
  input  dri_cmd_t                   cmd,
  output dri_sts_t                   sts,
  output logic [DRI_TDATA_OUT_W-1:0] out_data
);

  localparam int NSTEP = (CORDIC_STEPS < DRI_ATAN_DEPTH) ? CORDIC_STEPS : DRI_ATAN_DEPTH;

  logic signed [31:0] speed_gain, speed_offset, turn_gain, turn_offset;
  logic signed [15:0] raw_speed, raw_turn;
  logic signed [47:0] sp_prod, tn_prod;
  logic signed [31:0] speed;
  logic        [31:0] heading;
  logic        [1:0]  quad;
  logic signed [33:0] cx, cy;
  logic signed [32:0] cz;
  logic        [4:0]  idx;
  logic signed [65:0] prod;
  logic signed [47:0] x_acc, y_acc;
  logic               clip;

  logic signed [47:0] pos_x_o, pos_y_o;
  logic        [31:0] heading_o;
  logic signed [31:0] speed_o;
  logic               sat_o;

  logic signed [34:0] spd_sum;
  logic signed [31:0] spd_sat;
  logic        [31:0] turn_amt, heading_next;
  logic signed [33:0] xs, ys;
  logic signed [32:0] atan_v;
  logic signed [33:0] cos_v, sin_v, mul_b;
  logic signed [35:0] delta;
  logic signed [47:0] acc_sel;
  logic signed [48:0] pos_sum;
  logic               pos_ovf;
  logic signed [47:0] pos_new;

  // scaled speed, saturated to 32 bits
  assign spd_sum = {sp_prod[47], sp_prod[47:14]} + {{3{speed_offset[31]}}, speed_offset};
  always_comb begin
    if (spd_sum[34:31] == 4'b0000 || spd_sum[34:31] == 4'b1111) begin
      spd_sat = spd_sum[31:0];
    end else if (spd_sum[34]) begin
      spd_sat = 32'sh8000_0000;
    end else begin
      spd_sat = 32'sh7FFF_FFFF;
    end
  end

  assign turn_amt     = tn_prod[45:14] + turn_offset;
  assign heading_next = heading + turn_amt;

  // one micro-rotation per cycle
  assign xs     = cx >>> idx;
  assign ys     = cy >>> idx;
  assign atan_v = {1'b0, dri_atan(idx)};
  assign sts.rot_last = (idx == 5'(NSTEP - 1));

  always_comb begin
    case (quad)
      DRI_QUAD_0: begin cos_v = cx;  sin_v = cy;  end
      DRI_QUAD_1: begin cos_v = -cy; sin_v = cx;  end
      DRI_QUAD_2: begin cos_v = -cx; sin_v = -cy; end
      default:    begin cos_v = cy;  sin_v = -cx; end
    endcase
  end
  assign mul_b = cmd.muly ? sin_v : cos_v;

  // saturating position add, shared by x and y
  assign delta   = prod[65:30];
  assign acc_sel = cmd.accy ? y_acc : x_acc;
  assign pos_sum = {acc_sel[47], acc_sel} + {{13{delta[35]}}, delta};
  assign pos_ovf = pos_sum[48] != pos_sum[47];
  assign pos_new = !pos_ovf ? pos_sum[47:0] : (pos_sum[48] ? DRI_POS_MIN : DRI_POS_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_gain   <= DRI_SPEED_GAIN_RST;
      speed_offset <= DRI_SPEED_OFFSET_RST;
      turn_gain    <= DRI_TURN_GAIN_RST;
      turn_offset  <= DRI_TURN_OFFSET_RST;
      heading      <= '0;
      x_acc        <= '0;
      y_acc        <= '0;
      idx          <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          DRI_REG_SPEED_GAIN:   speed_gain   <= cfg_data;
          DRI_REG_SPEED_OFFSET: speed_offset <= cfg_data;
          DRI_REG_TURN_GAIN:    turn_gain    <= cfg_data;
          DRI_REG_TURN_OFFSET:  turn_offset  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.update) begin
        heading <= heading_next;
        idx     <= '0;
      end
      if (cmd.rot) begin
        idx <= idx + 5'd1;
      end
      if (cmd.accx) begin
        x_acc <= pos_new;
      end
      if (cmd.accy) begin
        y_acc <= pos_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_speed <= in_data[15:0];
      raw_turn  <= in_data[31:16];
    end
    if (cmd.scale) begin
      sp_prod <= raw_speed * speed_gain;
      tn_prod <= raw_turn * turn_gain;
    end
    if (cmd.update) begin
      speed <= spd_sat;
      quad  <= heading_next[31:30];
      cx    <= DRI_CORDIC_K;
      cy    <= '0;
      cz    <= {3'b000, heading_next[29:0]};
      clip  <= 1'b0;
    end
    if (cmd.rot) begin
      if (!cz[32]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - atan_v;
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + atan_v;
      end
    end
    if (cmd.mulx || cmd.muly) begin
      prod <= speed * mul_b;
    end
    if (cmd.accx || cmd.accy) begin
      clip <= clip | pos_ovf;
    end
    if (cmd.emit) begin
      pos_x_o   <= x_acc;
      pos_y_o   <= y_acc;
      heading_o <= heading;
      speed_o   <= speed;
      sat_o     <= clip;
    end
  end

  assign out_data = {7'd0, sat_o, speed_o, heading_o, pos_y_o, pos_x_o};

endmodule

/* rtl/dead_reckoning_pose_integrator.sv */
// dead_reckoning_pose_integrator: top level of the fixed-point pose integrator
// depends on dri_pkg, dri_ctrl and dri_datapath
//
// usage:
//  - input stream s_*: one transaction per frame, s_tdata = {raw_turn, raw_speed},
//    both signed Q2.14; raw_speed in the low half
//  - output stream m_*: one transaction per input, carrying the pose after that frame
//  - configuration channel cfg_*: index 0 speed_gain, 1 speed_offset, 2 turn_gain,
//    3 turn_offset; other indexes are dropped; always ready, write only while idle
// timing:
//  - an item goes from accept through scale, heading update, the cordic micro-rotations,
//    the x and y multiply-accumulates and the output load to m_tvalid; the shared cordic
//    micro-rotation unit runs one step per cycle, plus one shared 32x34 multiplier
//    used once for x and once for y
//  - one item is in flight at a time; s_tready is high only while the sequencer idles,
//    so a new input is not accepted until the previous result is in the output register
// reset:
//  - synchronous rst restores the default gains and offsets and clears x, y and heading
// stall:
//  - a result sits in the output register until taken; the next input may already be
//    accepted and worked on, and its result waits until the register is free
module dead_reckoning_pose_integrator
  import dri_pkg::*;
#(
  parameter int CORDIC_STEPS = DRI_CORDIC_STEPS
) (
  input  logic                       clk,
  input  logic                       rst,
  // input stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [DRI_TDATA_IN_W-1:0]  s_tdata,   // [15:0] raw_speed, [31:16] raw_turn
  // output stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [47:0] pos_x, [95:48] pos_y, [127:96] heading, [159:128] speed,
  // [160] saturated, [167:161] zero
  output logic [DRI_TDATA_OUT_W-1:0] m_tdata,
  // configuration writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [DRI_CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                cfg_data
);

  dri_cmd_t cmd;
  dri_sts_t sts;
  logic     cfg_we;

  // register writes are always accepted and go straight into the registers
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // sequencer: handshakes and the order of datapath steps
  dri_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // arithmetic: scaling, heading wrap, cordic, saturating position sums
  dri_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (m_tdata)
  );

endmodule

/* test/tb_dead_reckoning_pose_integrator.sv */
`timescale 1ns / 1ps
// tb_dead_reckoning_pose_integrator: self-checking bench for the fixed-point pose integrator
// runs directed, random and full-speed frames and compares every pose with its own predictor
// depends on dri_pkg and dead_reckoning_pose_integrator
module tb_dead_reckoning_pose_integrator;
  import dri_pkg::*;

  localparam int ROT_STEPS        = DRI_CORDIC_STEPS;
  localparam int RANDOM_PER_PHASE = 80;
  // short run at -45 degrees and full speed, largest position steps each frame
  localparam int SAT_FRAMES       = 32;
  localparam int HOLD_CYCLES      = 300;
  localparam int TAIL_CYCLES      = 4 * ROT_STEPS + 32;
  localparam int MAX_PRINTS       = 40;

  // out-of-range register indexes, the block must drop these writes
  localparam logic [DRI_CFG_IDX_W-1:0] IDX_PAST_LAST = DRI_REG_TURN_OFFSET + 1;
  localparam logic [DRI_CFG_IDX_W-1:0] IDX_TOP       = '1;

  localparam logic [31:0] WORD_MIN = 32'h8000_0000;
  localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;

  localparam longint SPEED_HI = 64'sd2147483647;
  localparam longint SPEED_LO = -64'sd2147483648;
  localparam longint POS_HI   = longint'(DRI_POS_MAX);
  localparam longint POS_LO   = longint'(DRI_POS_MIN);
  localparam longint ROT_GAIN = 64'sh26DD3B6A;

  // arctangent of 2^-i as binary angle, entry 0 in the top word
  localparam logic [32*32-1:0] ATAN_Q32 = {
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [15:0] raw_speed;
    logic [15:0] raw_turn;
  } frame_t;

  typedef struct packed {
    logic [47:0] pos_x;
    logic [47:0] pos_y;
    logic [31:0] heading;
    logic [31:0] speed;
    logic        saturated;
  } pose_t;

  // dut ports, all inputs known from time zero
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [DRI_TDATA_IN_W-1:0]  s_tdata = '0;   // [15:0] raw_speed, [31:16] raw_turn
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  // [47:0] pos_x, [95:48] pos_y, [127:96] heading, [159:128] speed,
  // [160] saturated, [167:161] zero
  logic [DRI_TDATA_OUT_W-1:0] m_tdata;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [DRI_CFG_IDX_W-1:0]   cfg_index = '0;
  logic [31:0]                cfg_data = '0;

  // register copies, starting at their reset values
  logic signed [31:0] k_speed_mul = DRI_SPEED_GAIN_RST;
  logic signed [31:0] k_speed_add = DRI_SPEED_OFFSET_RST;
  logic signed [31:0] k_turn_mul  = DRI_TURN_GAIN_RST;
  logic signed [31:0] k_turn_add  = DRI_TURN_OFFSET_RST;

  // predicted pose state
  logic [31:0] hdg_now = '0;
  longint      x_now   = 0;
  longint      y_now   = 0;

  frame_t frames_pending[$];
  pose_t  poses_expected[$];
  int     frames_queued = 0;
  int     poses_seen    = 0;
  int     mismatches    = 0;

  // pacing knobs, percent of cycles the sender idles / the receiver stalls
  int     idle_pct  = 0;
  int     stall_pct = 0;
  logic   hold_kick = 1'b0;
  int     hold_left = 0;

  dead_reckoning_pose_integrator #(
    .CORDIC_STEPS(ROT_STEPS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // one frame of dead reckoning: scale, turn, rotate, integrate with clipping
  function automatic pose_t predict_pose(input logic [15:0] rs_bits, input logic [15:0] rt_bits);
    longint vel, turn, rx, ry, rz, sx, sy, cosv, sinv, nx, ny;
    pose_t  p;
    vel  = ((longint'($signed(rs_bits)) * longint'(k_speed_mul)) >>> 14)
           + longint'(k_speed_add);
    turn = ((longint'($signed(rt_bits)) * longint'(k_turn_mul)) >>> 14)
           + longint'(k_turn_add);
    // speed clips silently to 32 bits
    if (vel > SPEED_HI) begin
      vel = SPEED_HI;
    end else if (vel < SPEED_LO) begin
      vel = SPEED_LO;
    end
    hdg_now = hdg_now + turn[31:0];

    // rotate (K, 0) through the angle inside the quadrant
    rx = ROT_GAIN;
    ry = 0;
    rz = longint'({34'd0, hdg_now[29:0]});
    for (int i = 0; i < ROT_STEPS && i < 32; i++) begin
      sx = rx >>> i;
      sy = ry >>> i;
      if (rz >= 0) begin
        rx = rx - sy;
        ry = ry + sx;
        rz = rz - longint'({32'd0, ATAN_Q32[(31 - i) * 32 +: 32]});
      end else begin
        rx = rx + sy;
        ry = ry - sx;
        rz = rz + longint'({32'd0, ATAN_Q32[(31 - i) * 32 +: 32]});
      end
    end

    // fold back onto the full circle
    case (hdg_now[31:30])
      DRI_QUAD_0: begin
        cosv = rx;
        sinv = ry;
      end
      DRI_QUAD_1: begin
        cosv = -ry;
        sinv = rx;
      end
      DRI_QUAD_2: begin
        cosv = -rx;
        sinv = -ry;
      end
      default: begin
        cosv = ry;
        sinv = -rx;
      end
    endcase

    nx = x_now + ((vel * cosv) >>> 30);
    ny = y_now + ((vel * sinv) >>> 30);
    p.saturated = 1'b0;
    if (nx > POS_HI) begin
      nx = POS_HI;
      p.saturated = 1'b1;
    end else if (nx < POS_LO) begin
      nx = POS_LO;
      p.saturated = 1'b1;
    end
    if (ny > POS_HI) begin
      ny = POS_HI;
      p.saturated = 1'b1;
    end else if (ny < POS_LO) begin
      ny = POS_LO;
      p.saturated = 1'b1;
    end
    x_now     = nx;
    y_now     = ny;
    p.pos_x   = nx[47:0];
    p.pos_y   = ny[47:0];
    p.heading = hdg_now;
    p.speed   = vel[31:0];
    return p;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatches < MAX_PRINTS) begin
      $display("%0t ns pose %0d: %s got %h want %h", $time, poses_seen, what, got, want);
    end
    mismatches++;
  endtask

  // input side: a new frame goes on the bus once the previous one is taken
  always @(posedge clk) begin : frame_source
    frame_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      // the predictor advances on each accepted transaction
      if (s_tvalid && s_tready) begin
        poses_expected.push_back(predict_pose(s_tdata[15:0], s_tdata[31:16]));
      end
      if (!s_tvalid || s_tready) begin
        if (frames_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = frames_pending.pop_front();
          s_tdata  <= {nxt.raw_turn, nxt.raw_speed};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted on its own
  always @(posedge clk) begin
    if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output side: compare each pose with the oldest prediction
  always @(posedge clk) begin : pose_sink
    pose_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (poses_expected.size() == 0) begin
          flag_mismatch("unexpected pose", m_tdata[63:0], '0);
        end else begin
          want = poses_expected.pop_front();
          if (m_tdata[47:0] !== want.pos_x)
            flag_mismatch("pos_x", 64'(m_tdata[47:0]), 64'(want.pos_x));
          if (m_tdata[95:48] !== want.pos_y)
            flag_mismatch("pos_y", 64'(m_tdata[95:48]), 64'(want.pos_y));
          if (m_tdata[127:96] !== want.heading)
            flag_mismatch("heading", 64'(m_tdata[127:96]), 64'(want.heading));
          if (m_tdata[159:128] !== want.speed)
            flag_mismatch("speed", 64'(m_tdata[159:128]), 64'(want.speed));
          if (m_tdata[160] !== want.saturated)
            flag_mismatch("saturated", 64'(m_tdata[160]), 64'(want.saturated));
          if (m_tdata[167:161] !== '0)
            flag_mismatch("padding", 64'(m_tdata[167:161]), '0);
          poses_seen <= poses_seen + 1;
        end
      end
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  // stimulus helpers, all run from the stimulus process

  // register write while the block is idle, keeps the register copies in step
  task automatic write_reg(input logic [DRI_CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      DRI_REG_SPEED_GAIN:   k_speed_mul = val;
      DRI_REG_SPEED_OFFSET: k_speed_add = val;
      DRI_REG_TURN_GAIN:    k_turn_mul  = val;
      DRI_REG_TURN_OFFSET:  k_turn_add  = val;
      default: ;
    endcase
  endtask

  // pacing changes and queue pushes happen on the falling edge
  task automatic set_pace(input int idle, input int stall);
    @(negedge clk);
    idle_pct  = idle;
    stall_pct = stall;
  endtask

  task automatic push_frame(input logic [15:0] rs, input logic [15:0] rt);
    frames_pending.push_back('{raw_speed: rs, raw_turn: rt});
    frames_queued++;
  endtask

  // blocks until every queued frame has come back as a pose
  task automatic wait_for_poses();
    @(posedge clk);
    while (poses_seen != frames_queued) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_raw();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_random(input int n);
    for (int k = 0; k < n; k++) begin
      push_frame(pick_raw(), pick_raw());
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // registers at reset values, field extremes
    set_pace(0, 0);
    push_frame(16'h0000, 16'h0000);
    push_frame(16'h7FFF, 16'h7FFF);
    push_frame(16'h8000, 16'h8000);
    push_frame(16'h7FFF, 16'h8000);
    push_frame(16'h8000, 16'h7FFF);
    push_frame(16'hFFFF, 16'h0001);
    push_frame(16'h0001, 16'hFFFF);
    push_frame(16'h4000, 16'hC000);
    wait_for_poses();

    // unit speed, fixed turn: bring the heading to zero, then quarter turns hit every axis
    write_reg(DRI_REG_SPEED_GAIN, 32'd0);
    write_reg(DRI_REG_SPEED_OFFSET, 32'h0100_0000);
    write_reg(DRI_REG_TURN_GAIN, 32'd0);
    write_reg(DRI_REG_TURN_OFFSET, 32'd0 - hdg_now);
    set_pace(0, 0);
    push_frame(pick_raw(), pick_raw());
    wait_for_poses();
    write_reg(DRI_REG_TURN_OFFSET, 32'h4000_0000);
    // writes past the last register must leave everything alone
    write_reg(IDX_PAST_LAST, WORD_MAX);
    write_reg(IDX_TOP, WORD_MIN);
    set_pace(0, 0);
    repeat (4) push_frame(pick_raw(), pick_raw());
    wait_for_poses();
    write_reg(DRI_REG_TURN_OFFSET, 32'h3000_0001);
    set_pace(0, 0);
    repeat (4) push_frame(pick_raw(), pick_raw());
    wait_for_poses();

    // register extremes: speed clips both ways, turn wraps
    write_reg(DRI_REG_SPEED_GAIN, WORD_MIN);
    write_reg(DRI_REG_SPEED_OFFSET, WORD_MIN);
    write_reg(DRI_REG_TURN_GAIN, WORD_MIN);
    write_reg(DRI_REG_TURN_OFFSET, WORD_MAX);
    set_pace(0, 0);
    push_frame(16'h7FFF, 16'h7FFF);
    push_frame(16'h8000, 16'h8000);
    push_frame(16'h0000, 16'h0000);
    wait_for_poses();
    write_reg(DRI_REG_SPEED_GAIN, WORD_MAX);
    write_reg(DRI_REG_SPEED_OFFSET, WORD_MAX);
    write_reg(DRI_REG_TURN_GAIN, WORD_MAX);
    write_reg(DRI_REG_TURN_OFFSET, WORD_MIN);
    set_pace(0, 0);
    push_frame(16'h7FFF, 16'h8000);
    push_frame(16'h8000, 16'h7FFF);
    push_frame(16'h0000, 16'h0000);
    wait_for_poses();

    // random frames under fresh registers, one pacing mode per phase
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(DRI_REG_SPEED_GAIN, pick_word());
      write_reg(DRI_REG_SPEED_OFFSET, pick_word());
      write_reg(DRI_REG_TURN_GAIN, pick_word());
      write_reg(DRI_REG_TURN_OFFSET, pick_word());
      case (ph)
        0:       set_pace(0, 0);
        1:       set_pace(83, 0);
        2:       set_pace(0, 83);
        default: set_pace(16, 16);
      endcase
      push_random(RANDOM_PER_PHASE);
      // receiver goes quiet while frames keep coming, so the input backs up
      if (ph == 0) begin
        hold_kick = 1'b1;
        @(negedge clk);
        hold_kick = 1'b0;
      end
      wait_for_poses();
    end

    // full speed at -45 degrees: x grows and y falls by the largest steps
    write_reg(DRI_REG_SPEED_GAIN, WORD_MAX);
    write_reg(DRI_REG_SPEED_OFFSET, WORD_MAX);
    write_reg(DRI_REG_TURN_GAIN, 32'd0);
    write_reg(DRI_REG_TURN_OFFSET, 32'hE000_0000 - hdg_now);
    set_pace(0, 0);
    push_frame(16'h0001, pick_raw());
    wait_for_poses();
    write_reg(DRI_REG_TURN_OFFSET, 32'd0);
    set_pace(0, 0);
    for (int k = 0; k < SAT_FRAMES; k++) begin
      push_frame(16'($urandom_range(32767, 1)), pick_raw());
    end
    wait_for_poses();

    // reverse at full speed
    write_reg(DRI_REG_SPEED_GAIN, 32'd0);
    write_reg(DRI_REG_SPEED_OFFSET, WORD_MIN);
    set_pace(0, 0);
    push_random(12);
    wait_for_poses();

    // let any stray pose show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (poses_expected.size() != 0) begin
      flag_mismatch("poses never delivered", 64'(poses_expected.size()), '0);
    end
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/dri_pkg.sv
rtl/dri_ctrl.sv
rtl/dri_datapath.sv
rtl/dead_reckoning_pose_integrator.sv
test/tb_dead_reckoning_pose_integrator.sv
